[hdl/kli_pkg.sv]
// ---------------------------------------------------------------------------
// kli_pkg: shared definitions for the keyframe linear interpolator
// widths, command and register codes, divider result bundle
// ---------------------------------------------------------------------------
`default_nettype none

package kli_pkg;

    // default table sizes
    localparam int DEF_MAX_KEYS     = 32;
    localparam int DEF_MAX_CHANNELS = 16;

    // field widths
    localparam int CMD_W        = 2;
    localparam int KEY_INDEX_W  = 5;
    localparam int CHANNEL_W    = 4;
    localparam int KEY_TIME_W   = 17;
    localparam int VALUE_W      = 32;
    localparam int SAMPLE_W     = 32;
    localparam int OUT_INDEX_W  = 9;
    localparam int FRAC_W       = 16;
    localparam int BLEND_W      = 17;
    localparam int DIFF_W       = 18;

    // stream beat widths
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_TIME  = 2'd0,
        CMD_LOAD_VALUE = 2'd1,
        CMD_EVALUATE   = 2'd2,
        CMD_NOP        = 2'd3
    } cmd_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_KEY_COUNT     = 2'd0,
        REG_CHANNEL_COUNT = 2'd1,
        REG_OUTPUT_BASE   = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_index_t;

    // divider result: done pulse and blend factor (unsigned Q1.16)
    typedef struct packed {
        logic               done;
        logic [BLEND_W-1:0] blend;
    } div_result_t;

endpackage

`default_nettype wire

[hdl/kli_ram.sv]
// ---------------------------------------------------------------------------
// kli_ram: generic simple dual port ram
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module kli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hdl/kli_div.sv]
// ---------------------------------------------------------------------------
// kli_div: serial blend divider
// floor((num << 16) / den) saturated to [0, 1.0], one quotient bit a cycle
// ---------------------------------------------------------------------------
`default_nettype none

module kli_div
    import kli_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic signed [DIFF_W-1:0] num,
    input  wire logic signed [DIFF_W-1:0] den,
    output div_result_t                   result
);

    localparam int MAG_W = DIFF_W - 1;
    localparam int Q_W   = FRAC_W;
    localparam int CNT_W = $clog2(Q_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MAG_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0] dvs_reg, dvs_next;
    logic [Q_W-1:0]   quo_reg, quo_next;
    logic             sat_reg, sat_next;

    logic             num_neg, den_neg, zero_q;
    logic [MAG_W-1:0] num_abs, den_abs;
    logic [MAG_W:0]   rem_sh;
    logic [MAG_W+1:0] trial;
    logic             fits;

    assign num_neg = num[DIFF_W-1];
    assign den_neg = den[DIFF_W-1];
    assign num_abs = num_neg ? MAG_W'(-num) : MAG_W'(num);
    assign den_abs = den_neg ? MAG_W'(-den) : MAG_W'(den);
    // negative quotient and zero divisor both end up at zero
    assign zero_q  = (den == '0) || (num == '0) || (num_neg != den_neg);

    // shared restoring step
    assign rem_sh = {rem_reg, 1'b0};
    assign trial  = {1'b0, rem_sh} - {2'b00, dvs_reg};
    assign fits   = !trial[MAG_W+1];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        sat_next  = sat_reg;
        if (start) begin
            if (zero_q) begin
                quo_next  = '0;
                sat_next  = 1'b0;
                done_next = 1'b1;
            end else if (num_abs >= den_abs) begin
                quo_next  = '0;
                sat_next  = 1'b1;
                done_next = 1'b1;
            end else begin
                busy_next = 1'b1;
                cnt_next  = '0;
                rem_next  = num_abs;
                dvs_next  = den_abs;
                quo_next  = '0;
                sat_next  = 1'b0;
            end
        end else if (busy_reg) begin
            rem_next = fits ? trial[MAG_W-1:0] : rem_sh[MAG_W-1:0];
            quo_next = {quo_reg[Q_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(Q_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
        sat_reg <= sat_next;
    end

    assign result.done  = done_reg;
    assign result.blend = {sat_reg, quo_reg};

endmodule

`default_nettype wire

[hdl/keyframe_linear_interpolator_unit.sv]
// ---------------------------------------------------------------------------
// keyframe_linear_interpolator_unit: piecewise linear keyframe interpolator
// key time and key value tables, bracket scan, serial blend, per channel lerp
// ---------------------------------------------------------------------------
// usage
//   input beats on s_*: tuser carries the command (load key time, load key
//   value, evaluate), tdata the key index, channel, key time, key value and
//   sample time. load beats leave the sequencer idle and give no result beat.
//   an evaluate beat gives one m_* beat per channel in channel order, tdata
//   holding output slot and value, tlast high on the final channel.
//   registers are written through cfg_we / cfg_addr / cfg_wdata; the user
//   must write them only while idle, the block does not enforce it.
// sequencing
//   a sample time at or below 0 or at or above 1.0 skips the scan and the
//   divider; when the blend needs no division the divider skips its bit steps.
//   the scan reads one key time a cycle from the time ram, the divider
//   produces one blend bit a cycle, and each channel takes two reads of the
//   value ram, a subtract, a multiply and the output load on the one shared
//   lerp datapath. s_tready is high only while the sequencer is idle.
// reset and stall
//   reset returns the sequencer to idle, drops m_tvalid and restores the
//   register defaults; the key tables are not cleared and must be loaded.
//   a stalled receiver holds the output register and the sequencer waits
//   in its output step; a loaded beat may wait while the next is accepted.
// ---------------------------------------------------------------------------
`default_nettype none

module keyframe_linear_interpolator_unit
    import kli_pkg::*;
#(
    parameter int MAX_KEYS     = DEF_MAX_KEYS,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input channel
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // tdata: key_index, channel, key_time, key_value, sample_time, zero pad
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // tuser: command
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    // result channel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // tdata: out_index, out_value, zero pad
    output logic [M_TDATA_W-1:0]       m_tdata,
    output logic                       m_tlast,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int KW     = $clog2(MAX_KEYS);
    localparam int CW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int VAW    = CW + KW;
    localparam int VDEPTH = 2 ** VAW;
    localparam int DV_W   = VALUE_W + 1;
    localparam int PROD_W = DV_W + BLEND_W + 1;

    // one-hot sequencer states
    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_SCAN = 11'b000_0000_0010,   // pipelined key time scan
        ST_TLO  = 11'b000_0000_0100,   // read lower key time
        ST_THI  = 11'b000_0000_1000,   // read upper key time
        ST_TCAP = 11'b000_0001_0000,   // launch divider
        ST_DIV  = 11'b000_0010_0000,   // wait for blend
        ST_VLO  = 11'b000_0100_0000,   // read lower key value
        ST_VHI  = 11'b000_1000_0000,   // read upper key value
        ST_VDIF = 11'b001_0000_0000,   // upper minus lower
        ST_VMUL = 11'b010_0000_0000,   // scale by blend
        ST_VOUT = 11'b100_0000_0000    // load output register
    } state_t;

    // input beat fields
    cmd_t                       in_cmd;
    logic [KEY_INDEX_W-1:0]     in_key_index;
    logic [CHANNEL_W-1:0]       in_channel;
    logic [KEY_TIME_W-1:0]      in_key_time;
    logic [VALUE_W-1:0]         in_key_value;
    logic signed [SAMPLE_W-1:0] in_sample_time;

    assign in_cmd         = cmd_t'(s_tuser[CMD_W-1:0]);
    assign in_key_index   = s_tdata[4:0];
    assign in_channel     = s_tdata[8:5];
    assign in_key_time    = s_tdata[25:9];
    assign in_key_value   = s_tdata[57:26];
    assign in_sample_time = $signed(s_tdata[89:58]);

    // state
    state_t                     state_reg, state_next;
    logic [KW-1:0]              scan_idx_reg, scan_idx_next;
    logic [KW-1:0]              chk_idx_reg, chk_idx_next;
    logic                       chk_valid_reg, chk_valid_next;
    logic [KW-1:0]              lo_reg, lo_next;
    logic [KW-1:0]              hi_reg, hi_next;
    logic [KEY_TIME_W-1:0]      t_reg, t_next;
    logic [KEY_TIME_W-1:0]      tl_reg, tl_next;
    logic [BLEND_W-1:0]         blend_reg, blend_next;
    logic [CW-1:0]              ch_reg, ch_next;
    logic [VALUE_W-1:0]         a_reg, a_next;
    logic signed [DV_W-1:0]     diff_reg, diff_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [OUT_INDEX_W-1:0]     out_index_reg, out_index_next;
    logic [VALUE_W-1:0]         out_value_reg, out_value_next;
    logic                       out_last_reg, out_last_next;
    logic [5:0]                 key_count_reg, key_count_next;
    logic [4:0]                 channel_count_reg, channel_count_next;
    logic [7:0]                 output_base_reg, output_base_next;

    logic                       in_accept;
    logic [KW-1:0]              n_m1;
    logic [CW-1:0]              nc_m1;
    logic                       t_le0, t_ge1;

    // table ports
    logic                       time_we, value_we;
    logic [KW-1:0]              time_waddr, time_raddr;
    logic [KEY_TIME_W-1:0]      time_rdata;
    logic [VAW-1:0]             value_waddr, value_raddr;
    logic [VALUE_W-1:0]         value_rdata;

    // divider
    logic                       div_start;
    logic signed [DIFF_W-1:0]   div_num, div_den;
    div_result_t                div_res;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // effective key count minus one, saturated to [2, MAX_KEYS]
    always_comb begin
        if (key_count_reg < 6'd2) begin
            n_m1 = KW'(1);
        end else if (int'(key_count_reg) > MAX_KEYS) begin
            n_m1 = KW'(MAX_KEYS - 1);
        end else begin
            n_m1 = KW'(key_count_reg - 6'd1);
        end
    end

    // effective channel count minus one, saturated to [1, MAX_CHANNELS]
    always_comb begin
        if (channel_count_reg == 5'd0) begin
            nc_m1 = '0;
        end else if (int'(channel_count_reg) > MAX_CHANNELS) begin
            nc_m1 = CW'(MAX_CHANNELS - 1);
        end else begin
            nc_m1 = CW'(channel_count_reg - 5'd1);
        end
    end

    // sample time outside the open unit interval
    assign t_le0 = in_sample_time[SAMPLE_W-1] || (in_sample_time == '0);
    assign t_ge1 = !in_sample_time[SAMPLE_W-1] && (|in_sample_time[SAMPLE_W-2:FRAC_W]);

    // table writes from load beats, out of range loads dropped
    assign time_we     = in_accept && (in_cmd == CMD_LOAD_TIME)
                         && (int'(in_key_index) < MAX_KEYS);
    assign time_waddr  = KW'(in_key_index);
    assign value_we    = in_accept && (in_cmd == CMD_LOAD_VALUE)
                         && (int'(in_key_index) < MAX_KEYS)
                         && (int'(in_channel) < MAX_CHANNELS);
    assign value_waddr = {CW'(in_channel), KW'(in_key_index)};

    always_comb begin
        case (state_reg)
            ST_SCAN: time_raddr = scan_idx_reg;
            ST_TLO:  time_raddr = lo_reg;
            default: time_raddr = hi_reg;
        endcase
    end

    assign value_raddr = {ch_reg, (state_reg == ST_VLO) ? lo_reg : hi_reg};

    // divider operands: t - t_lo over t_hi - t_lo
    assign div_start = (state_reg == ST_TCAP);
    assign div_num   = $signed({1'b0, t_reg}) - $signed({1'b0, tl_reg});
    assign div_den   = $signed({1'b0, time_rdata}) - $signed({1'b0, tl_reg});

    // sequencer
    always_comb begin
        state_next         = state_reg;
        scan_idx_next      = scan_idx_reg;
        chk_idx_next       = chk_idx_reg;
        chk_valid_next     = chk_valid_reg;
        lo_next            = lo_reg;
        hi_next            = hi_reg;
        t_next             = t_reg;
        tl_next            = tl_reg;
        blend_next         = blend_reg;
        ch_next            = ch_reg;
        a_next             = a_reg;
        diff_next          = diff_reg;
        prod_next          = prod_reg;
        out_index_next     = out_index_reg;
        out_value_next     = out_value_reg;
        out_last_next      = out_last_reg;
        m_tvalid_next      = m_tvalid_reg && !m_tready;
        key_count_next     = key_count_reg;
        channel_count_next = channel_count_reg;
        output_base_next   = output_base_reg;

        if (cfg_we) begin
            case (reg_index_t'(cfg_addr))
                REG_KEY_COUNT:     key_count_next     = cfg_wdata[5:0];
                REG_CHANNEL_COUNT: channel_count_next = cfg_wdata[4:0];
                REG_OUTPUT_BASE:   output_base_next   = cfg_wdata;
                default:           ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept && (in_cmd == CMD_EVALUATE)) begin
                    ch_next    = '0;
                    blend_next = '0;
                    if (t_le0) begin
                        lo_next    = '0;
                        hi_next    = '0;
                        state_next = ST_VLO;
                    end else if (t_ge1) begin
                        lo_next    = n_m1;
                        hi_next    = n_m1;
                        state_next = ST_VLO;
                    end else begin
                        t_next = KEY_TIME_W'(in_sample_time[FRAC_W-1:0]);
                        if (n_m1 == KW'(1)) begin
                            // two keys: no interior key to scan
                            lo_next    = '0;
                            hi_next    = KW'(1);
                            state_next = ST_TLO;
                        end else begin
                            scan_idx_next  = KW'(1);
                            chk_valid_next = 1'b0;
                            state_next     = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                scan_idx_next  = scan_idx_reg + KW'(1);
                chk_idx_next   = scan_idx_reg;
                chk_valid_next = 1'b1;
                if (chk_valid_reg) begin
                    if (t_reg < time_rdata) begin
                        hi_next    = chk_idx_reg;
                        lo_next    = chk_idx_reg - KW'(1);
                        state_next = ST_TLO;
                    end else if (chk_idx_reg == n_m1 - KW'(1)) begin
                        // no interior key above t: last segment
                        hi_next    = n_m1;
                        lo_next    = chk_idx_reg;
                        state_next = ST_TLO;
                    end
                end
            end
            ST_TLO: begin
                state_next = ST_THI;
            end
            ST_THI: begin
                tl_next    = time_rdata;
                state_next = ST_TCAP;
            end
            ST_TCAP: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_res.done) begin
                    blend_next = div_res.blend;
                    state_next = ST_VLO;
                end
            end
            ST_VLO: begin
                state_next = ST_VHI;
            end
            ST_VHI: begin
                a_next     = value_rdata;
                state_next = ST_VDIF;
            end
            ST_VDIF: begin
                diff_next  = $signed({value_rdata[VALUE_W-1], value_rdata})
                             - $signed({a_reg[VALUE_W-1], a_reg});
                state_next = ST_VMUL;
            end
            ST_VMUL: begin
                prod_next  = PROD_W'(diff_reg * $signed({1'b0, blend_reg}));
                state_next = ST_VOUT;
            end
            ST_VOUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next  = 1'b1;
                    out_index_next = OUT_INDEX_W'(output_base_reg) + OUT_INDEX_W'(ch_reg);
                    // lo + floor((hi - lo) * blend / 1.0)
                    out_value_next = a_reg + prod_reg[FRAC_W+VALUE_W-1:FRAC_W];
                    out_last_next  = (ch_reg == nc_m1);
                    if (ch_reg == nc_m1) begin
                        state_next = ST_IDLE;
                    end else begin
                        ch_next    = ch_reg + CW'(1);
                        state_next = ST_VLO;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            chk_valid_reg     <= 1'b0;
            m_tvalid_reg      <= 1'b0;
            key_count_reg     <= 6'd2;
            channel_count_reg <= 5'd1;
            output_base_reg   <= 8'd0;
        end else begin
            state_reg         <= state_next;
            chk_valid_reg     <= chk_valid_next;
            m_tvalid_reg      <= m_tvalid_next;
            key_count_reg     <= key_count_next;
            channel_count_reg <= channel_count_next;
            output_base_reg   <= output_base_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg  <= scan_idx_next;
        chk_idx_reg   <= chk_idx_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        t_reg         <= t_next;
        tl_reg        <= tl_next;
        blend_reg     <= blend_next;
        ch_reg        <= ch_next;
        a_reg         <= a_next;
        diff_reg      <= diff_next;
        prod_reg      <= prod_next;
        out_index_reg <= out_index_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    // key time table
    kli_ram #(
        .WIDTH (KEY_TIME_W),
        .DEPTH (MAX_KEYS)
    ) u_time_ram (
        .aclk    (aclk),
        .wr_en   (time_we),
        .wr_addr (time_waddr),
        .wr_data (in_key_time),
        .rd_addr (time_raddr),
        .rd_data (time_rdata)
    );

    // key value table, channel major
    kli_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (VDEPTH)
    ) u_value_ram (
        .aclk    (aclk),
        .wr_en   (value_we),
        .wr_addr (value_waddr),
        .wr_data (in_key_value),
        .rd_addr (value_raddr),
        .rd_data (value_rdata)
    );

    // serial blend divider
    kli_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .result  (div_res)
    );

    // result beat
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - VALUE_W - OUT_INDEX_W){1'b0}}, out_value_reg, out_index_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for keyframe_linear_interpolator_unit
// loads key time and key value tables, sends evaluate beats and compares
// every result beat with a bit-exact lerp predictor or a hand-typed value held in the bench
// ---------------------------------------------------------------------------

module tb;
    import kli_pkg::*;

    localparam int  CLK_PERIOD    = 8;
    localparam int  RESET_CYCLES  = 6;
    localparam int  CYCLE_LIMIT   = 1000000;
    localparam int  SETTLE_CYCLES = 150;
    localparam int  RANDOM_BEATS  = 470;
    localparam int  CALM_FROM     = 200;   // beats with no idling on either side
    localparam int  CALM_TO       = 290;
    localparam int  N_DIRECTED    = 22;
    localparam int  ONE_Q16       = 65536;
    localparam int  KEYS          = DEF_MAX_KEYS;
    localparam int  CHANS         = DEF_MAX_CHANNELS;

    // one input beat, split into its fields
    typedef struct packed {
        cmd_t        cmd;
        logic [4:0]  key;
        logic [3:0]  chan;
        logic [16:0] ktime;
        logic [31:0] kval;
        logic [31:0] stime;
    } kf_item_t;

    // one result beat as expected on m_*
    typedef struct packed {
        logic [8:0]  slot;
        logic [31:0] value;
        logic        tail;
    } lerp_beat_t;

    // directed row: a beat, plus a hand-typed value where it is obvious
    typedef struct packed {
        kf_item_t    beat;
        logic        typed;
        logic [31:0] want;
    } step_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // tdata: key_index [4:0], channel [8:5], key_time [25:9],
    //        key_value [57:26], sample_time [89:58], zero pad
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    // tuser: command
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // tdata: out_index [8:0], out_value [40:9], zero pad
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    keyframe_linear_interpolator_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ---------------------------------------------------------------------
    // shadow state of the block
    // ---------------------------------------------------------------------
    logic [16:0] shadow_times  [KEYS];
    logic [31:0] shadow_values [CHANS][KEYS];
    bit          time_loaded   [KEYS];
    bit          value_loaded  [CHANS][KEYS];
    logic [5:0]  cur_key_count  = 6'd2;
    logic [4:0]  cur_chan_count = 5'd1;
    logic [7:0]  cur_out_base   = 8'd0;

    lerp_beat_t  pending_beats [$];
    int          beats_in   = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    // directed rows, reset settings: two keys, one channel, base slot 0
    step_row_t directed_plan [N_DIRECTED] = '{
        // bracket 0 .. 1.0 with the most negative and most positive values
        '{'{CMD_LOAD_TIME,  5'd0, 4'd0, 17'h00000, 32'h0, 32'h0}, 1'b0, 32'h0},
        '{'{CMD_LOAD_TIME,  5'd1, 4'd0, 17'h10000, 32'h0, 32'h0}, 1'b0, 32'h0},
        '{'{CMD_LOAD_VALUE, 5'd0, 4'd0, 17'h0, 32'h8000_0000, 32'h0}, 1'b0, 32'h0},
        '{'{CMD_LOAD_VALUE, 5'd1, 4'd0, 17'h0, 32'h7fff_ffff, 32'h0}, 1'b0, 32'h0},
        // clamped times give the end keys straight through
        '{'{CMD_EVALUATE,   5'd0, 4'd0, 17'h0, 32'h0, 32'h0000_0000}, 1'b1, 32'h8000_0000},
        '{'{CMD_EVALUATE,   5'd0, 4'd0, 17'h0, 32'h0, 32'h8000_0000}, 1'b1, 32'h8000_0000},
        '{'{CMD_EVALUATE,   5'd0, 4'd0, 17'h0, 32'h0, 32'hffff_ffff}, 1'b1, 32'h8000_0000},
        '{'{CMD_EVALUATE,   5'd0, 4'd0, 17'h0, 32'h0, 32'h0001_0000}, 1'b1, 32'h7fff_ffff},
        '{'{CMD_EVALUATE,   5'd0, 4'd0, 17'h0, 32'h0, 32'h7fff_ffff}, 1'b1, 32'h7fff_ffff},
        // interior times just inside both ends and in the middle
        '{'{CMD_EVALUATE,   5'd0, 4'd0, 17'h0, 32'h0, 32'h0000_0001}, 1'b0, 32'h0},
        '{'{CMD_EVALUATE,   5'd0, 4'd0, 17'h0, 32'h0, 32'h0000_8000}, 1'b0, 32'h0},
        '{'{CMD_EVALUATE,   5'd0, 4'd0, 17'h0, 32'h0, 32'h0000_ffff}, 1'b0, 32'h0},
        // no-op command with every field bit set must leave state alone
        '{'{CMD_NOP, 5'h1f, 4'hf, 17'h1ffff, 32'hffff_ffff, 32'hffff_ffff}, 1'b0, 32'h0},
        '{'{CMD_EVALUATE,   5'd0, 4'd0, 17'h0, 32'h0, 32'h0000_4000}, 1'b0, 32'h0},
        // both key times equal: zero divisor forces blend 0, so key 0
        '{'{CMD_LOAD_TIME,  5'd1, 4'd0, 17'h00000, 32'h0, 32'h0}, 1'b0, 32'h0},
        '{'{CMD_EVALUATE,   5'd0, 4'd0, 17'h0, 32'h0, 32'h0000_0064}, 1'b1, 32'h8000_0000},
        // key time above 1.0 at key 0 gives an unordered pair
        '{'{CMD_LOAD_TIME,  5'd0, 4'd0, 17'h1ffff, 32'h0, 32'h0}, 1'b0, 32'h0},
        '{'{CMD_EVALUATE,   5'd0, 4'd0, 17'h0, 32'h0, 32'h0000_4000}, 1'b0, 32'h0},
        // ordered again but with the upper key above 1.0
        '{'{CMD_LOAD_TIME,  5'd0, 4'd0, 17'h00000, 32'h0, 32'h0}, 1'b0, 32'h0},
        '{'{CMD_LOAD_TIME,  5'd1, 4'd0, 17'h1ffff, 32'h0, 32'h0}, 1'b0, 32'h0},
        // small negative against the most negative value exercises floor rounding
        '{'{CMD_LOAD_VALUE, 5'd1, 4'd0, 17'h0, 32'hffff_ffff, 32'h0}, 1'b0, 32'h0},
        '{'{CMD_EVALUATE,   5'd0, 4'd0, 17'h0, 32'h0, 32'h0000_c001}, 1'b0, 32'h0}
    };

    function automatic int eff_keys();
        if (cur_key_count < 2)
            return 2;
        if (cur_key_count > KEYS)
            return KEYS;
        return int'(cur_key_count);
    endfunction

    function automatic int eff_chans();
        if (cur_chan_count < 1)
            return 1;
        if (cur_chan_count > CHANS)
            return CHANS;
        return int'(cur_chan_count);
    endfunction

    function automatic bit in_calm_window();
        return beats_in >= CALM_FROM && beats_in < CALM_TO;
    endfunction

    // the pair of keys that brackets time t
    function automatic void span_of(input longint t, input int n,
                                    output int lo, output int hi);
        int i;
        if (t <= 0) begin
            lo = 0;
            hi = 0;
        end else if (t >= ONE_Q16) begin
            lo = n - 1;
            hi = n - 1;
        end else begin
            i = 1;
            while (i < n - 1 && t >= longint'(shadow_times[i]))
                i++;
            hi = i;
            lo = i - 1;
        end
    endfunction

    // applies one accepted beat to the shadow state and queues its results
    function automatic void lerp_predict(kf_item_t it);
        int         n, nc, lo, hi;
        longint     t, den, num, blend, a, b, v;
        lerp_beat_t beat;
        case (it.cmd)
            CMD_LOAD_TIME: begin
                shadow_times[it.key] = it.ktime;
                time_loaded[it.key]  = 1'b1;
            end
            CMD_LOAD_VALUE: begin
                shadow_values[it.chan][it.key] = it.kval;
                value_loaded[it.chan][it.key]  = 1'b1;
            end
            CMD_EVALUATE: begin
                n     = eff_keys();
                nc    = eff_chans();
                t     = longint'(signed'(it.stime));
                blend = 0;
                span_of(t, n, lo, hi);
                if (t > 0 && t < ONE_Q16) begin
                    den = longint'(shadow_times[hi]) - longint'(shadow_times[lo]);
                    if (den != 0) begin
                        num   = (t - longint'(shadow_times[lo])) * ONE_Q16;
                        blend = num / den;
                        // floor, not truncation, when the signs differ
                        if (num % den != 0 && ((num < 0) != (den < 0)))
                            blend--;
                    end
                    if (blend < 0)
                        blend = 0;
                    if (blend > ONE_Q16)
                        blend = ONE_Q16;
                end
                for (int ch = 0; ch < nc; ch++) begin
                    a = longint'(signed'(shadow_values[ch][lo]));
                    b = longint'(signed'(shadow_values[ch][hi]));
                    v = (a * (ONE_Q16 - blend) + b * blend) >>> 16;
                    beat.slot  = 9'(int'(cur_out_base) + ch);
                    beat.value = v[31:0];
                    beat.tail  = (ch == nc - 1);
                    pending_beats.push_back(beat);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < 60)
            $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        mismatches++;
    endtask

    // drives one beat from a falling edge and holds it until it is taken
    task automatic send_item(kf_item_t it, logic typed, logic [31:0] want);
        lerp_beat_t fixed;
        if (!in_calm_window() && $urandom_range(99) < 12)
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {6'd0, it.stime, it.kval, it.ktime, it.chan, it.key};
        s_tuser  = it.cmd;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        beats_in++;
        if (typed) begin
            fixed.slot  = 9'd0;
            fixed.value = want;
            fixed.tail  = 1'b1;
            pending_beats.push_back(fixed);
        end else begin
            lerp_predict(it);
        end
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(reg_index_t idx, logic [7:0] val);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            REG_KEY_COUNT:     cur_key_count  = val[5:0];
            REG_CHANNEL_COUNT: cur_chan_count = val[4:0];
            REG_OUTPUT_BASE:   cur_out_base   = val;
            default: ;
        endcase
    endtask

    // waits until every expected beat is out and the sequencer has settled
    task automatic drain_results();
        while (pending_beats.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic kf_item_t noise_item(cmd_t cmd);
        kf_item_t it;
        it.cmd   = cmd;
        it.key   = 5'($urandom);
        it.chan  = 4'($urandom);
        it.ktime = 17'($urandom);
        it.kval  = $urandom;
        it.stime = $urandom;
        return it;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_sample_time();
        int r, k;
        r = $urandom_range(99);
        k = $urandom_range(eff_keys() - 1);
        if (r < 50)
            return 32'($urandom_range(1, ONE_Q16 - 1));
        if (r < 60)
            return time_loaded[k] ? 32'(shadow_times[k]) : 32'h8000;
        if (r < 70)
            return {1'b1, 31'($urandom)};
        if (r < 85)
            return 32'($urandom_range(ONE_Q16, 32'h7fff_ffff));
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'h8000_0000;
            2: return 32'h0001_0000;
            3: return 32'h7fff_ffff;
            4: return 32'h0000_ffff;
            default: return 32'h1;
        endcase
    endfunction

    // fills every entry an evaluate at this time will read, if still empty
    task automatic prime_for_eval(logic [31:0] st);
        int       n, nc, lo, hi;
        kf_item_t it;
        n  = eff_keys();
        nc = eff_chans();
        for (int k = 0; k < n; k++) begin
            if (!time_loaded[k]) begin
                it       = noise_item(CMD_LOAD_TIME);
                it.key   = 5'(k);
                it.ktime = (k == 0) ? 17'd0 : (k == n - 1) ? 17'(ONE_Q16)
                         : 17'($urandom_range(1, ONE_Q16 - 1));
                send_item(it, 1'b0, 32'h0);
            end
        end
        span_of(longint'(signed'(st)), n, lo, hi);
        for (int ch = 0; ch < nc; ch++) begin
            for (int k = 0; k < KEYS; k++) begin
                if ((k == lo || k == hi) && !value_loaded[ch][k]) begin
                    it      = noise_item(CMD_LOAD_VALUE);
                    it.chan = 4'(ch);
                    it.key  = 5'(k);
                    it.kval = pick_value();
                    send_item(it, 1'b0, 32'h0);
                end
            end
        end
    endtask

    // one setting of the registers, usually a fresh table, and a burst of beats
    task automatic run_phase();
        int       n, nc, burst, r;
        int       pts [$];
        kf_item_t it;
        drain_results();
        if ($urandom_range(99) < 70) begin
            write_reg(REG_KEY_COUNT, 8'($urandom_range(2, 6)));
            write_reg(REG_CHANNEL_COUNT, 8'($urandom_range(1, 4)));
        end else begin
            case ($urandom_range(4))
                0: write_reg(REG_KEY_COUNT, 8'd0);
                1: write_reg(REG_KEY_COUNT, 8'd1);
                2: write_reg(REG_KEY_COUNT, 8'd32);
                3: write_reg(REG_KEY_COUNT, 8'd33);
                default: write_reg(REG_KEY_COUNT, 8'd63);
            endcase
            case ($urandom_range(4))
                0: write_reg(REG_CHANNEL_COUNT, 8'd0);
                1: write_reg(REG_CHANNEL_COUNT, 8'd1);
                2: write_reg(REG_CHANNEL_COUNT, 8'd16);
                3: write_reg(REG_CHANNEL_COUNT, 8'd17);
                default: write_reg(REG_CHANNEL_COUNT, 8'd31);
            endcase
        end
        case ($urandom_range(3))
            0: write_reg(REG_OUTPUT_BASE, 8'd0);
            1: write_reg(REG_OUTPUT_BASE, 8'd255);
            default: write_reg(REG_OUTPUT_BASE, 8'($urandom));
        endcase
        n  = eff_keys();
        nc = eff_chans();

        r = $urandom_range(99);
        if (r < 80) begin
            // well-formed: 0, sorted interior (some repeated), 1.0
            for (int k = 1; k < n - 1; k++)
                pts.push_back($urandom_range(1, ONE_Q16 - 1));
            pts.sort();
            for (int k = 1; k < pts.size(); k++)
                if ($urandom_range(99) < 15)
                    pts[k] = pts[k - 1];
            pts.push_front(0);
            pts.push_back(ONE_Q16);
            for (int k = 0; k < n; k++) begin
                it       = noise_item(CMD_LOAD_TIME);
                it.key   = 5'(k);
                it.ktime = 17'(pts[k]);
                send_item(it, 1'b0, 32'h0);
            end
        end else if (r < 90) begin
            // scrambled times, some of them above 1.0
            for (int k = 0; k < n; k++) begin
                it     = noise_item(CMD_LOAD_TIME);
                it.key = 5'(k);
                send_item(it, 1'b0, 32'h0);
            end
        end
        // otherwise keep whatever the last phase left behind

        if (n * nc <= 64) begin
            for (int ch = 0; ch < nc; ch++) begin
                for (int k = 0; k < n; k++) begin
                    it      = noise_item(CMD_LOAD_VALUE);
                    it.chan = 4'(ch);
                    it.key  = 5'(k);
                    it.kval = pick_value();
                    send_item(it, 1'b0, 32'h0);
                end
            end
        end

        burst = $urandom_range(10, 30);
        for (int j = 0; j < burst; j++) begin
            r = $urandom_range(99);
            if (r < 70) begin
                it       = noise_item(CMD_EVALUATE);
                it.stime = pick_sample_time();
                prime_for_eval(it.stime);
            end else if (r < 80) begin
                it      = noise_item(CMD_LOAD_VALUE);
                it.kval = pick_value();
            end else if (r < 88) begin
                // stray time load, usually breaks the ordering
                it = noise_item(CMD_LOAD_TIME);
                if ($urandom_range(1))
                    it.ktime = 17'($urandom_range(0, ONE_Q16));
            end else begin
                it = noise_item(CMD_NOP);
            end
            send_item(it, 1'b0, 32'h0);
        end
    endtask

    // ---------------------------------------------------------------------
    // receiver: stalls now and then, never inside the calm window
    // ---------------------------------------------------------------------
    always @(negedge aclk) begin
        m_tready <= in_calm_window() ? 1'b1 : ($urandom_range(99) >= 12);
    end

    // result checker, oldest expectation first
    always @(posedge aclk) begin : result_check
        lerp_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_beats.size() == 0) begin
                report_mismatch("unexpected result beat, tdata", 32'(m_tdata[40:9]), 32'h0);
            end else begin
                want = pending_beats.pop_front();
                if (m_tdata[8:0] != want.slot)
                    report_mismatch("out_index", 32'(m_tdata[8:0]), 32'(want.slot));
                if (m_tdata[40:9] != want.value)
                    report_mismatch("out_value", m_tdata[40:9], want.value);
                if (m_tlast != want.tail)
                    report_mismatch("tlast", 32'(m_tlast), 32'(want.tail));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("keyframe_linear_interpolator_unit test failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------
    initial begin : stimulus
        kf_item_t it;
        int       directed_beats;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed part at reset settings
        for (int i = 0; i < N_DIRECTED; i++) begin
            it = directed_plan[i].beat;
            send_item(it, directed_plan[i].typed, directed_plan[i].want);
        end
        directed_beats = beats_in;

        // random phases, each opening with a full drain before reconfiguring
        while (beats_in - directed_beats < RANDOM_BEATS)
            run_phase();

        drain_results();
        if (mismatches == 0)
            $display("keyframe_linear_interpolator_unit test passed");
        else
            $display("keyframe_linear_interpolator_unit test failed");
        $finish;
    end

endmodule
